// ===== src/hue_window_skin_classifier_unit_assert.svh =====
`ifndef HUE_WINDOW_SKIN_CLASSIFIER_UNIT_ASSERT_SVH
`define HUE_WINDOW_SKIN_CLASSIFIER_UNIT_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define HWSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check an implication on every rising edge outside reset.
`define HWSC_ASSERT_IMPL(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

`endif

// ===== src/hwsc_pkg.sv =====
package hwsc_pkg;

  localparam int FRAC_BITS = 8;
  localparam int CH_W      = 8;
  localparam int BOUND_W   = 9;
  localparam int DIV_W     = 9;
  localparam int NUM_W     = 17;
  localparam int QUO_W     = CH_W + FRAC_BITS;
  localparam int CFG_IDX_W = 1;

  localparam logic [CH_W-1:0] HUE_SCALE     = 8'd85;
  localparam logic [CH_W-1:0] BASE_RED      = 8'd0;
  localparam logic [CH_W-1:0] BASE_GREEN    = 8'd85;
  localparam logic [CH_W-1:0] BASE_BLUE     = 8'd170;
  localparam logic [CH_W-1:0] BASE_RED_WRAP = 8'd255;

  localparam logic [BOUND_W-1:0] WINDOW_LOW_RST  = 9'd7;
  localparam logic [BOUND_W-1:0] WINDOW_HIGH_RST = 9'd57;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LOW  = 1'b0,
    CFG_WINDOW_HIGH = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [CH_W-1:0] hue_byte;
    logic            in_window;
  } result_t;

  typedef struct packed {
    logic [CH_W-1:0]  base;
    logic [CH_W-1:0]  pos;
    logic [CH_W-1:0]  neg;
    logic [DIV_W-1:0] divisor;
  } sel_t;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] divisor;
    logic [QUO_W-1:0] feed;
  } div_t;

endpackage

// ===== src/hwsc_prep.sv =====
module hwsc_prep (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            advance,
  input  logic            in_valid,
  input  hwsc_pkg::pixel_t in_pix,
  output logic            out_valid,
  output hwsc_pkg::div_t  out_div
);
  import hwsc_pkg::*;

  logic [CH_W-1:0]  mx;
  logic [CH_W-1:0]  mn;
  logic [CH_W-1:0]  span;
  sel_t             sel_nxt;
  sel_t             sel_r;
  logic             sel_valid_r;
  logic [NUM_W-1:0] num;
  div_t             div_nxt;
  div_t             div_r;
  logic             div_valid_r;

  always_comb begin
    mx = in_pix.red;
    mn = in_pix.red;
    if (in_pix.green > mx) mx = in_pix.green;
    if (in_pix.blue > mx) mx = in_pix.blue;
    if (in_pix.green < mn) mn = in_pix.green;
    if (in_pix.blue < mn) mn = in_pix.blue;
    span = mx - mn;
    sel_nxt.divisor = {span, 1'b0};
    priority if (span == '0) begin
      sel_nxt.base    = BASE_RED;
      sel_nxt.pos     = '0;
      sel_nxt.neg     = '0;
      sel_nxt.divisor = DIV_W'(1);
    end else if (mx == in_pix.blue) begin
      sel_nxt.base = BASE_BLUE;
      sel_nxt.pos  = in_pix.red;
      sel_nxt.neg  = in_pix.green;
    end else if (mx == in_pix.green) begin
      sel_nxt.base = BASE_GREEN;
      sel_nxt.pos  = in_pix.blue;
      sel_nxt.neg  = in_pix.red;
    end else begin
      sel_nxt.base = (in_pix.green >= in_pix.blue) ? BASE_RED : BASE_RED_WRAP;
      sel_nxt.pos  = in_pix.green;
      sel_nxt.neg  = in_pix.blue;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_valid_r <= 1'b0;
    end else if (advance) begin
      sel_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sel_r <= sel_nxt;
    end
  end

  always_comb begin
    num             = NUM_W'(sel_r.base) * NUM_W'(sel_r.divisor)
                    + NUM_W'(HUE_SCALE) * NUM_W'(sel_r.pos)
                    - NUM_W'(HUE_SCALE) * NUM_W'(sel_r.neg);
    div_nxt.rem     = num[NUM_W-1:CH_W];
    div_nxt.divisor = sel_r.divisor;
    div_nxt.feed    = {num[CH_W-1:0], {FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_valid_r <= 1'b0;
    end else if (advance) begin
      div_valid_r <= sel_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      div_r <= div_nxt;
    end
  end

  assign out_valid = div_valid_r;
  assign out_div   = div_r;

endmodule

// ===== src/hwsc_div_step.sv =====
module hwsc_div_step (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           advance,
  input  logic           in_valid,
  input  hwsc_pkg::div_t in_div,
  output logic           out_valid,
  output hwsc_pkg::div_t out_div
);
  import hwsc_pkg::*;

  logic [DIV_W:0]   trial;
  logic [DIV_W-1:0] diff;
  logic             ge;
  div_t             div_nxt;
  div_t             div_r;
  logic             valid_r;

  always_comb begin
    trial           = {in_div.rem, in_div.feed[QUO_W-1]};
    diff            = trial[DIV_W-1:0] - in_div.divisor;
    ge              = trial >= {1'b0, in_div.divisor};
    div_nxt.rem     = ge ? diff : trial[DIV_W-1:0];
    div_nxt.divisor = in_div.divisor;
    div_nxt.feed    = {in_div.feed[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      div_r <= div_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_div   = div_r;

endmodule

// ===== src/hwsc_window.sv =====
module hwsc_window (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            advance,
  input  logic                            in_valid,
  input  hwsc_pkg::div_t                  in_div,
  input  logic [hwsc_pkg::BOUND_W-1:0]    low_half,
  input  logic [hwsc_pkg::BOUND_W-1:0]    high_half,
  output logic                            out_valid,
  output hwsc_pkg::result_t               out_res
);
  import hwsc_pkg::*;

  logic [QUO_W:0] twice;
  logic [QUO_W:0] low_fix;
  logic [QUO_W:0] high_fix;
  result_t        res_nxt;
  result_t        res_r;
  logic           valid_r;

  always_comb begin
    twice             = {in_div.feed, 1'b0};
    low_fix           = {low_half, {FRAC_BITS{1'b0}}};
    high_fix          = {high_half, {FRAC_BITS{1'b0}}};
    res_nxt.hue_byte  = in_div.feed[QUO_W-1:FRAC_BITS];
    res_nxt.in_window = (twice >= low_fix) && (twice <= high_fix);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== src/hue_window_skin_classifier_unit.sv =====
// Classifies RGB pixels by HSV hue: one pixel is taken every clock while
// in_stall is low, and the results leave in input order. The hue (full turn =
// 255) is held with FRAC_BITS fraction bits; out_data.hue_byte is its integer
// part and out_data.in_window is set when low/2 <= hue <= high/2 for the two
// window registers (reset 7 and 57; a low bound above the high bound never
// matches; grey pixels have hue 0). The quotient comes from a restoring
// divider, which forms one quotient bit per pipeline stage. Write the window
// registers only while no pixel is in flight. A stall on the result side
// freezes the whole pipeline and shows on in_stall.
module hue_window_skin_classifier_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  hwsc_pkg::pixel_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output hwsc_pkg::result_t                out_data,
  input  logic                             cfg_we,
  input  logic [hwsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hwsc_pkg::BOUND_W-1:0]     cfg_wdata
);
  import hwsc_pkg::*;

  logic               advance;
  logic [BOUND_W-1:0] low_half_r;
  logic [BOUND_W-1:0] high_half_r;
  logic [QUO_W:0]     div_valid;
  div_t               div_data [QUO_W+1];

  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_half_r  <= WINDOW_LOW_RST;
      high_half_r <= WINDOW_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_LOW:  low_half_r  <= cfg_wdata;
        CFG_WINDOW_HIGH: high_half_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  hwsc_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .in_valid  (in_valid),
    .in_pix    (in_data),
    .out_valid (div_valid[0]),
    .out_div   (div_data[0])
  );

  for (genvar s = 0; s < QUO_W; s++) begin : g_div
    hwsc_div_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .advance   (advance),
      .in_valid  (div_valid[s]),
      .in_div    (div_data[s]),
      .out_valid (div_valid[s+1]),
      .out_div   (div_data[s+1])
    );
  end

  hwsc_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .in_valid  (div_valid[QUO_W]),
    .in_div    (div_data[QUO_W]),
    .low_half  (low_half_r),
    .high_half (high_half_r),
    .out_valid (out_valid),
    .out_res   (out_data)
  );

`include "hue_window_skin_classifier_unit_assert.svh"

  `HWSC_ASSERT_IMPL(a_hue_below_full, out_valid, out_data.hue_byte != 8'hFF, "hue byte reached 255")
  `HWSC_ASSERT_IMPL(a_inverted_window, out_valid && (low_half_r > high_half_r), !out_data.in_window, "inverted window matched")
  `HWSC_ASSERT_IMPL(a_full_window, out_valid && (low_half_r == '0) && (high_half_r == '1), out_data.in_window, "full window missed")
  `HWSC_ASSERT(a_stall_freezes, (out_valid && out_stall) |=> $stable(div_valid), "pipeline moved while stalled")

endmodule
